/* rtl/core/spt_pkg.sv */
package spt_pkg;

    localparam int PIXEL_FRAC_BITS = 4;
    localparam int OUT_FRAC_BITS   = 16;

    localparam int PIX_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_FRAC  = 8;
    localparam int OUT_W     = 32;

    // ray components, signed with RAY_FRAC fraction bits
    localparam int RAY_FRAC  = 16;
    localparam int RAY_W     = CFG_W + 1;
    localparam int RNUM_W    = RAY_W + RAY_FRAC;
    localparam int RAY_Q_W   = CFG_W;
    localparam int RAY_HI_W  = RNUM_W - RAY_Q_W;

    // solver word widths
    localparam int DIFF_W    = RAY_W + 1;
    localparam int CROSS_W   = 2 * RAY_W;
    localparam int SPLIT     = RAY_W;
    localparam int CH_W      = CROSS_W - SPLIT;
    localparam int D_W       = 99;
    localparam int NPART_W   = 75;
    localparam int NH_W      = NPART_W - 2 * SPLIT;
    localparam int NUM_W     = 100;

    // output divider
    localparam int Q_W       = OUT_W;
    localparam int M_W       = NUM_W + OUT_FRAC_BITS + 1;
    localparam int HI_W      = M_W - 2 - Q_W;

    localparam int RAY_LAT      = RAY_Q_W + 2;
    localparam int QUOT_LAT     = Q_W + 1;
    localparam int SOLVE_STAGES = 9;
    localparam int PIPE_LAT     = 1 + RAY_LAT + SOLVE_STAGES + QUOT_LAT + 1;

    localparam logic [CFG_W-1:0] FOCAL_RESET = CFG_W'(128000);
    localparam logic [CFG_W-1:0] CX_RESET    = CFG_W'(81920);
    localparam logic [CFG_W-1:0] CY_RESET    = CFG_W'(61440);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_FOCAL_X   = 3'd0,
        CFG_LEFT_FOCAL_Y   = 3'd1,
        CFG_LEFT_CENTER_X  = 3'd2,
        CFG_LEFT_CENTER_Y  = 3'd3,
        CFG_RIGHT_FOCAL_X  = 3'd4,
        CFG_RIGHT_FOCAL_Y  = 3'd5,
        CFG_RIGHT_CENTER_X = 3'd6,
        CFG_RIGHT_CENTER_Y = 3'd7
    } cfg_index_t;

endpackage

/* rtl/core/spt_ray_div.sv */
module spt_ray_div
    import spt_pkg::*;
(
    input  logic                    clk,
    input  logic [RNUM_W-1:0]       num,
    input  logic                    neg,
    input  logic [CFG_W-1:0]        focal,
    output logic signed [RAY_W-1:0] ray
);

    logic [RAY_Q_W-1:0] rem_reg [0:RAY_Q_W];
    logic [RAY_Q_W-1:0] low_reg [0:RAY_Q_W];
    logic               neg_reg [0:RAY_Q_W];
    logic               sat_reg [0:RAY_Q_W];
    logic [RAY_Q_W-1:0] rem_next [1:RAY_Q_W];
    logic [RAY_Q_W-1:0] low_next [1:RAY_Q_W];
    logic [RAY_Q_W-1:0] rem0;
    logic [RAY_Q_W-1:0] mag;
    logic signed [RAY_W-1:0] ray_reg;

    assign rem0 = RAY_Q_W'(num[RNUM_W-1:RAY_Q_W]);

    always_comb
    begin
        logic [RAY_Q_W:0] t;
        logic             ge;
        for (int k = 0; k < RAY_Q_W; k++)
        begin
            t  = {rem_reg[k], low_reg[k][RAY_Q_W-1]};
            ge = t >= {1'b0, focal};
            rem_next[k+1] = ge ? RAY_Q_W'(t - {1'b0, focal}) : t[RAY_Q_W-1:0];
            low_next[k+1] = {low_reg[k][RAY_Q_W-2:0], ge};
        end
    end

    assign mag = sat_reg[RAY_Q_W] ? {RAY_Q_W{1'b1}} : low_reg[RAY_Q_W];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem0;
        low_reg[0] <= num[RAY_Q_W-1:0];
        neg_reg[0] <= neg;
        sat_reg[0] <= rem0 >= focal;
        for (int k = 1; k <= RAY_Q_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            neg_reg[k] <= neg_reg[k-1];
            sat_reg[k] <= sat_reg[k-1];
        end
        ray_reg <= neg_reg[RAY_Q_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign ray = ray_reg;

endmodule

/* rtl/core/spt_quot_div.sv */
module spt_quot_div
    import spt_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num_mag,
    input  logic             num_neg,
    input  logic [D_W-1:0]   den,
    output logic [Q_W-1:0]   quot,
    output logic             big,
    output logic             neg
);

    logic [D_W-1:0] rem_reg [0:Q_W];
    logic [Q_W-1:0] low_reg [0:Q_W];
    logic [D_W-1:0] den_reg [0:Q_W];
    logic           big_reg [0:Q_W];
    logic           neg_reg [0:Q_W];
    logic [D_W-1:0] rem_next [1:Q_W];
    logic [Q_W-1:0] low_next [1:Q_W];
    logic [M_W-1:0] m;
    logic [D_W-1:0] rem0;

    // rounding term 2*den, then divide by 4*den
    assign m    = {1'b0, num_mag, {OUT_FRAC_BITS{1'b0}}} + M_W'({den, 1'b0});
    assign rem0 = D_W'(m[M_W-1:Q_W+2]);

    always_comb
    begin
        logic [D_W:0] t;
        logic         ge;
        for (int k = 0; k < Q_W; k++)
        begin
            t  = {rem_reg[k], low_reg[k][Q_W-1]};
            ge = t >= {1'b0, den_reg[k]};
            rem_next[k+1] = ge ? D_W'(t - {1'b0, den_reg[k]}) : t[D_W-1:0];
            low_next[k+1] = {low_reg[k][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem0;
        low_reg[0] <= m[Q_W+1:2];
        den_reg[0] <= den;
        big_reg[0] <= rem0 >= den;
        neg_reg[0] <= num_neg;
        for (int k = 1; k <= Q_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            den_reg[k] <= den_reg[k-1];
            big_reg[k] <= big_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    assign quot = low_reg[Q_W];
    assign big  = big_reg[Q_W];
    assign neg  = neg_reg[Q_W];

endmodule

/* rtl/core/stereo_point_triangulation.sv */
// stereo point triangulation
// input: one matched pixel pair (left_u, left_v, right_u, right_v) is taken
// at each rising edge with start high and busy low; busy is always low, so
// a new item may enter every cycle
// output: point_x, point_y, point_z (signed, 15 fraction bits), in_front
// and degenerate are valid for exactly one cycle while done is high
// throughput is one item per cycle; the pipeline is set by the two
// restoring dividers, one step per stage: 26 stages for the ray
// back-projection and 33 for the output quotients, plus the entry stage,
// nine solver stages and the output stage
// configuration: cfg_write with cfg_index and cfg_data writes one camera
// register; write only while no item is in flight
// reset clears the item pipeline and loads the default camera intrinsics;
// the receiver cannot stall, results leave on the strobe
module stereo_point_triangulation
    import spt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic [PIX_W-1:0]        left_u,
    input  logic [PIX_W-1:0]        left_v,
    input  logic [PIX_W-1:0]        right_u,
    input  logic [PIX_W-1:0]        right_v,
    output logic                    done,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic signed [OUT_W-1:0] point_z,
    output logic                    in_front,
    output logic                    degenerate
);

    localparam logic signed [OUT_W+1:0] SAT_HI = {3'b000, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W+1:0] SAT_LO = {3'b111, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W+1:0] X_OFS  = (OUT_W+2)'(1) << (OUT_FRAC_BITS - 2);

    // camera registers
    logic [CFG_W-1:0] lfx_reg, lfy_reg, lcx_reg, lcy_reg;
    logic [CFG_W-1:0] rfx_reg, rfy_reg, rcx_reg, rcy_reg;
    logic             focal_zero;

    logic                accept;
    logic [PIPE_LAT-1:0] vld_reg;

    // lanes: 0 left x, 1 left y, 2 right x, 3 right y
    logic [PIX_W-1:0]  lane_pix    [0:3];
    logic [CFG_W-1:0]  lane_center [0:3];
    logic [CFG_W-1:0]  lane_focal  [0:3];
    logic [RNUM_W-1:0] rnum_reg    [0:3];
    logic              rneg_reg    [0:3];
    logic signed [RAY_W-1:0] ray   [0:3];

    logic signed [RAY_W-1:0] ray_a_reg [0:3];
    logic signed [RAY_W-1:0] ray_b_reg [0:3];
    logic signed [RAY_W-1:0] ray_c_reg [0:3];
    logic signed [RAY_W-1:0] ray_d_reg [0:3];
    logic signed [RAY_W-1:0] ray_e_reg [0:3];

    logic signed [DIFF_W-1:0]   a_reg, b_reg, b_b_reg, b_c_reg, b_d_reg;
    logic signed [CROSS_W-1:0]  p1_reg, p2_reg, c_reg;
    logic signed [2*DIFF_W-1:0] a2_reg, b2_reg;
    logic [2*DIFF_W-1:0]        ab2_reg, ab2_d_reg;

    logic signed [CH_W-1:0]         chs;
    logic [SPLIT-1:0]               cl;
    logic signed [2*CH_W-1:0]       sq_hh_reg;
    logic signed [CH_W+SPLIT:0]     sq_hl_reg;
    logic [2*SPLIT-1:0]             sq_ll_reg;
    logic signed [CH_W+RAY_W-1:0]   cy1h_reg, cy2h_reg;
    logic signed [SPLIT+RAY_W:0]    cy1l_reg, cy2l_reg;

    logic [D_W-1:0]              csq_reg;
    logic signed [NPART_W-1:0]   cy1_reg, cy2_reg;
    logic [D_W-1:0]              d_e_reg, d_f_reg, d_g_reg, d_h_reg, d_i_reg;
    logic signed [NPART_W-1:0]   n1_reg, n2_reg;

    logic signed [NPART_W-1:0]     n_sel [0:3];
    logic signed [RAY_W-1:0]       r_sel [0:3];
    logic signed [NH_W+RAY_W-1:0]  ph_reg [0:3];
    logic signed [SPLIT+RAY_W:0]   pm_reg [0:3];
    logic signed [SPLIT+RAY_W:0]   pl_reg [0:3];
    logic signed [NPART_W:0]       nzs_reg, nzs_g_reg;
    logic signed [NUM_W-1:0]       prod_reg [0:3];
    logic signed [NUM_W-1:0]       nx_reg, ny_reg, nz_reg;
    logic                          dz_h_reg, dz_i_reg;
    logic [NUM_W-1:0]              mag_reg [0:2];
    logic                          neg_reg [0:2];
    logic [QUOT_LAT-1:0]           dz_pipe_reg;

    logic [Q_W-1:0] q_mag [0:2];
    logic           q_big [0:2];
    logic           q_neg [0:2];

    logic                    degen;
    logic signed [OUT_W-1:0] px, py, pz;
    logic signed [OUT_W-1:0] point_x_reg, point_y_reg, point_z_reg;
    logic                    in_front_reg, degenerate_reg;

    function automatic logic [RNUM_W:0] ray_num(
        input logic [PIX_W-1:0] pix,
        input logic [CFG_W-1:0] center,
        input logic [CFG_W-1:0] focal
    );
        logic signed [RAY_W-1:0] n;
        logic [RAY_W-1:0]        a;
        n = $signed(RAY_W'(pix) << (CFG_FRAC - PIXEL_FRAC_BITS)) - $signed({1'b0, center});
        a = n[RAY_W-1] ? RAY_W'(-n) : n;
        return {n[RAY_W-1], RNUM_W'({a, {RAY_FRAC{1'b0}}}) + RNUM_W'(focal >> 1)};
    endfunction

    function automatic logic signed [OUT_W-1:0] fin(
        input logic [Q_W-1:0]            mag,
        input logic                      big,
        input logic                      neg,
        input logic signed [OUT_W+1:0]   ofs
    );
        logic signed [OUT_W+1:0] v;
        v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        v = v + ofs;
        if (big)
        begin
            v = neg ? SAT_LO : SAT_HI;
        end
        else if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[OUT_W-1:0];
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfx_reg <= FOCAL_RESET;
            lfy_reg <= FOCAL_RESET;
            lcx_reg <= CX_RESET;
            lcy_reg <= CY_RESET;
            rfx_reg <= FOCAL_RESET;
            rfy_reg <= FOCAL_RESET;
            rcx_reg <= CX_RESET;
            rcy_reg <= CY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEFT_FOCAL_X:   lfx_reg <= cfg_data;
                CFG_LEFT_FOCAL_Y:   lfy_reg <= cfg_data;
                CFG_LEFT_CENTER_X:  lcx_reg <= cfg_data;
                CFG_LEFT_CENTER_Y:  lcy_reg <= cfg_data;
                CFG_RIGHT_FOCAL_X:  rfx_reg <= cfg_data;
                CFG_RIGHT_FOCAL_Y:  rfy_reg <= cfg_data;
                CFG_RIGHT_CENTER_X: rcx_reg <= cfg_data;
                CFG_RIGHT_CENTER_Y: rcy_reg <= cfg_data;
            endcase
        end
    end

    assign focal_zero = (lfx_reg == '0) || (lfy_reg == '0) || (rfx_reg == '0)
                        || (rfy_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], accept};
        end
    end

    always_comb
    begin
        lane_pix[0] = left_u;   lane_center[0] = lcx_reg; lane_focal[0] = lfx_reg;
        lane_pix[1] = left_v;   lane_center[1] = lcy_reg; lane_focal[1] = lfy_reg;
        lane_pix[2] = right_u;  lane_center[2] = rcx_reg; lane_focal[2] = rfx_reg;
        lane_pix[3] = right_v;  lane_center[3] = rcy_reg; lane_focal[3] = rfy_reg;
    end

    // entry stage: offset, magnitude and rounding term
    always_ff @(posedge clk)
    begin
        logic [RNUM_W:0] rn;
        for (int j = 0; j < 4; j++)
        begin
            rn = ray_num(lane_pix[j], lane_center[j], lane_focal[j]);
            rnum_reg[j] <= rn[RNUM_W-1:0];
            rneg_reg[j] <= rn[RNUM_W];
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_ray
        spt_ray_div u_ray_div (
            .clk   (clk),
            .num   (rnum_reg[j]),
            .neg   (rneg_reg[j]),
            .focal (lane_focal[j]),
            .ray   (ray[j])
        );
    end

    assign chs = c_reg[CROSS_W-1:SPLIT];
    assign cl  = c_reg[SPLIT-1:0];

    always_comb
    begin
        n_sel[0] = n1_reg; r_sel[0] = ray_e_reg[0];
        n_sel[1] = n2_reg; r_sel[1] = ray_e_reg[2];
        n_sel[2] = n1_reg; r_sel[2] = ray_e_reg[1];
        n_sel[3] = n2_reg; r_sel[3] = ray_e_reg[3];
    end

    always_ff @(posedge clk)
    begin
        // cross product terms
        a_reg  <= ray[1] - ray[3];
        b_reg  <= ray[2] - ray[0];
        p1_reg <= ray[0] * ray[3];
        p2_reg <= ray[1] * ray[2];

        c_reg   <= p1_reg - p2_reg;
        a2_reg  <= a_reg * a_reg;
        b2_reg  <= b_reg * b_reg;
        b_b_reg <= b_reg;

        // split products of the wide cross term
        sq_hh_reg <= chs * chs;
        sq_hl_reg <= chs * $signed({1'b0, cl});
        sq_ll_reg <= cl * cl;
        cy2h_reg  <= chs * ray_b_reg[3];
        cy2l_reg  <= $signed({1'b0, cl}) * ray_b_reg[3];
        cy1h_reg  <= chs * ray_b_reg[1];
        cy1l_reg  <= $signed({1'b0, cl}) * ray_b_reg[1];
        ab2_reg   <= $unsigned(a2_reg) + $unsigned(b2_reg);
        b_c_reg   <= b_b_reg;

        csq_reg   <= D_W'(((NUM_W+1)'(sq_hh_reg) << (2 * SPLIT))
                     + ((NUM_W+1)'(sq_hl_reg) << (SPLIT + 1))
                     + (NUM_W+1)'(sq_ll_reg));
        cy2_reg   <= (NPART_W'(cy2h_reg) <<< SPLIT) + NPART_W'(cy2l_reg);
        cy1_reg   <= (NPART_W'(cy1h_reg) <<< SPLIT) + NPART_W'(cy1l_reg);
        ab2_d_reg <= ab2_reg;
        b_d_reg   <= b_c_reg;

        // squared norm and numerator parts
        d_e_reg <= (D_W'(ab2_d_reg) << (2 * RAY_FRAC)) + csq_reg;
        n1_reg  <= cy2_reg - (NPART_W'(b_d_reg) <<< (2 * RAY_FRAC));
        n2_reg  <= cy1_reg - (NPART_W'(b_d_reg) <<< (2 * RAY_FRAC));

        for (int j = 0; j < 4; j++)
        begin
            ray_a_reg[j] <= ray[j];
            ray_b_reg[j] <= ray_a_reg[j];
            ray_c_reg[j] <= ray_b_reg[j];
            ray_d_reg[j] <= ray_c_reg[j];
            ray_e_reg[j] <= ray_d_reg[j];

            ph_reg[j] <= $signed(n_sel[j][NPART_W-1:2*SPLIT]) * r_sel[j];
            pm_reg[j] <= $signed({1'b0, n_sel[j][2*SPLIT-1:SPLIT]}) * r_sel[j];
            pl_reg[j] <= $signed({1'b0, n_sel[j][SPLIT-1:0]}) * r_sel[j];

            prod_reg[j] <= (NUM_W'(ph_reg[j]) <<< (2 * SPLIT))
                           + (NUM_W'(pm_reg[j]) <<< SPLIT) + NUM_W'(pl_reg[j]);
        end
        nzs_reg   <= n1_reg + n2_reg;
        d_f_reg   <= d_e_reg;
        nzs_g_reg <= nzs_reg;
        d_g_reg   <= d_f_reg;

        nx_reg   <= prod_reg[0] + prod_reg[1];
        ny_reg   <= prod_reg[2] + prod_reg[3];
        nz_reg   <= NUM_W'(nzs_g_reg) <<< RAY_FRAC;
        dz_h_reg <= d_g_reg == '0;
        d_h_reg  <= d_g_reg;

        neg_reg[0] <= nx_reg[NUM_W-1];
        neg_reg[1] <= ny_reg[NUM_W-1];
        neg_reg[2] <= nz_reg[NUM_W-1];
        mag_reg[0] <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : nx_reg;
        mag_reg[1] <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : ny_reg;
        mag_reg[2] <= nz_reg[NUM_W-1] ? NUM_W'(-nz_reg) : nz_reg;
        dz_i_reg   <= dz_h_reg;
        d_i_reg    <= d_h_reg;

        dz_pipe_reg <= {dz_pipe_reg[QUOT_LAT-2:0], dz_i_reg};
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_quot
        spt_quot_div u_quot_div (
            .clk     (clk),
            .num_mag (mag_reg[j]),
            .num_neg (neg_reg[j]),
            .den     (d_i_reg),
            .quot    (q_mag[j]),
            .big     (q_big[j]),
            .neg     (q_neg[j])
        );
    end

    assign degen = dz_pipe_reg[QUOT_LAT-1] || focal_zero;
    assign px    = degen ? '0 : fin(q_mag[0], q_big[0], q_neg[0], X_OFS);
    assign py    = degen ? '0 : fin(q_mag[1], q_big[1], q_neg[1], '0);
    assign pz    = degen ? '0 : fin(q_mag[2], q_big[2], q_neg[2], '0);

    always_ff @(posedge clk)
    begin
        point_x_reg    <= px;
        point_y_reg    <= py;
        point_z_reg    <= pz;
        in_front_reg   <= pz > 0;
        degenerate_reg <= degen;
    end

    assign done       = vld_reg[PIPE_LAT-1];
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign point_z    = point_z_reg;
    assign in_front   = in_front_reg;
    assign degenerate = degenerate_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> point_x == 0 && point_y == 0 && point_z == 0 && !in_front)
        else $error("degenerate item with nonzero point");

    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> in_front == (!degenerate && point_z > 0))
        else $error("in_front does not match depth");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result without an accepted item");

endmodule
